// ----- sv/tmhq_pkg.sv -----
// Package: types, constants and codes shared by the ternary max-heap queue.
package tmhq_pkg;

   localparam int CAPACITY = 64;
   localparam int KEY_BITS = 8;
   localparam int ID_BITS = 16;
   localparam int IDX_BITS = $clog2(CAPACITY);
   localparam int CNT_BITS = 7;
   // (x * DIV3_MUL) >> DIV3_SHIFT equals x / 3 for every slot index below CAPACITY
   localparam int DIV3_MUL = 43;
   localparam int DIV3_SHIFT = 7;

   typedef enum logic [1:0] {
      FUNC_INSERT  = 2'd0,
      FUNC_EXTRACT = 2'd1,
      FUNC_CHANGE  = 2'd2,
      FUNC_PEEK    = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_FULL      = 3'd2,
      ST_EMPTY     = 3'd3,
      ST_NOT_FOUND = 3'd4
   } status_type;

   typedef struct packed {
      logic [1:0]           func;
      logic [ID_BITS-1:0]   entry_id;
      logic [7:0]           entry_key;
   } req_type;

   typedef struct packed {
      logic [2:0]           status;
      logic [ID_BITS-1:0]   out_id;
      logic [7:0]           out_key;
      logic [CNT_BITS-1:0]  count;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECIDE,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_INS,
      S_ROOT_RD,
      S_ROOT_CHK,
      S_LAST_RD,
      S_LAST_CHK,
      S_UP_RD,
      S_UP_CHK,
      S_DN_RD,
      S_DN_CHK,
      S_DN_END,
      S_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;      // latch the request
      logic scan_start;    // clear the scan pointer
      logic scan_next;     // advance the scan pointer
      logic root_read;     // read slot 0
      logic latch_root;    // capture the root for the result
      logic last_read;     // read the last held slot
      logic load_last;     // take the last entry as the mover at the root, count--
      logic ins_start;     // mover is the new entry at slot count, count++
      logic chg_start;     // mover is the new key at the found slot
      logic up_read;       // read parent of the hole
      logic up_shift;      // move the parent down into the hole
      logic up_place;      // write the mover into the hole
      logic dn_read;       // read the current child of the hole
      logic dn_check;      // compare that child with the best so far
      logic dn_shift;      // move the best child up into the hole
      logic dn_place;      // write the mover into the hole
      logic set_status;    // record status code
      status_type status;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      func_type func;
      logic     empty;
      logic     full;
      logic     scan_hit;
      logic     scan_end;
      logic     key_up;     // new key greater than the old one
      logic     up_top;     // hole is the root
      logic     up_less;    // parent strictly smaller than the mover
      logic     dn_last;    // no further child to read in this round
      logic     dn_stay;    // no child beat the mover
   } sts_type;

endpackage

// ----- sv/ternary_max_heap_queue.sv -----
// Top level: ternary max-heap priority queue of (id, key) entries.
// The block holds up to 64 (id, key) entries in a 3-ary max-heap and takes one item at a
// time: insert (refused for an id already held, then for a full store), extract max,
// change key (refused for an id not held) and peek. Each item gives exactly one result
// carrying the status, the root id and key for extract and peek (zero otherwise) and the
// count after the operation. Unless the store is empty, an insert or change first scans the
// held entries one slot at a time for the id; an insert then sifts up level by level, a
// change sifts up or down, and an extract reads the root and the last entry and then sifts
// down, reading and comparing up to three children per level. The id scan sets the worst
// case. Hold the result until it is taken; the next item can be taken in the cycle after.
module ternary_max_heap_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  tmhq_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output tmhq_pkg::rsp_type  rsp_data
);

   tmhq_pkg::cmd_type cmd;
   tmhq_pkg::sts_type sts;

   tmhq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   tmhq_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

// ----- sv/tmhq_ctrl.sv -----
// Controller: sequences scan, update and sift steps for one request.
module tmhq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  tmhq_pkg::sts_type  sts,
   output tmhq_pkg::cmd_type  cmd
);

   tmhq_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tmhq_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tmhq_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = tmhq_pkg::S_DECIDE;
            end
         end
         tmhq_pkg::S_DECIDE: begin
            unique case (sts.func)
               tmhq_pkg::FUNC_INSERT: begin
                  state_in = sts.empty ? tmhq_pkg::S_INS : tmhq_pkg::S_SCAN_RD;
               end
               tmhq_pkg::FUNC_CHANGE: begin
                  state_in = sts.empty ? tmhq_pkg::S_DONE : tmhq_pkg::S_SCAN_RD;
               end
               tmhq_pkg::FUNC_EXTRACT, tmhq_pkg::FUNC_PEEK: begin
                  state_in = sts.empty ? tmhq_pkg::S_DONE : tmhq_pkg::S_ROOT_RD;
               end
            endcase
         end
         tmhq_pkg::S_SCAN_RD: state_in = tmhq_pkg::S_SCAN_CHK;
         tmhq_pkg::S_SCAN_CHK: begin
            if (sts.scan_hit) begin
               state_in = (sts.func == tmhq_pkg::FUNC_INSERT) ? tmhq_pkg::S_DONE
                        : (sts.key_up ? tmhq_pkg::S_UP_RD : tmhq_pkg::S_DN_RD);
            end else if (sts.scan_end) begin
               state_in = (sts.func == tmhq_pkg::FUNC_INSERT) ? tmhq_pkg::S_INS
                        : tmhq_pkg::S_DONE;
            end else begin
               state_in = tmhq_pkg::S_SCAN_RD;
            end
         end
         tmhq_pkg::S_INS: state_in = sts.full ? tmhq_pkg::S_DONE : tmhq_pkg::S_UP_RD;
         tmhq_pkg::S_ROOT_RD: state_in = tmhq_pkg::S_ROOT_CHK;
         tmhq_pkg::S_ROOT_CHK: begin
            state_in = (sts.func == tmhq_pkg::FUNC_PEEK) ? tmhq_pkg::S_DONE
                                                         : tmhq_pkg::S_LAST_RD;
         end
         tmhq_pkg::S_LAST_RD: state_in = tmhq_pkg::S_LAST_CHK;
         tmhq_pkg::S_LAST_CHK: state_in = tmhq_pkg::S_DN_RD;
         tmhq_pkg::S_UP_RD: state_in = tmhq_pkg::S_UP_CHK;
         tmhq_pkg::S_UP_CHK: begin
            if (sts.up_top) begin
               state_in = tmhq_pkg::S_DONE;
            end else if (sts.up_less) begin
               state_in = tmhq_pkg::S_UP_RD;
            end else begin
               state_in = tmhq_pkg::S_DONE;
            end
         end
         tmhq_pkg::S_DN_RD: state_in = tmhq_pkg::S_DN_CHK;
         tmhq_pkg::S_DN_CHK: state_in = sts.dn_last ? tmhq_pkg::S_DN_END : tmhq_pkg::S_DN_RD;
         tmhq_pkg::S_DN_END: state_in = sts.dn_stay ? tmhq_pkg::S_DONE : tmhq_pkg::S_DN_RD;
         tmhq_pkg::S_DONE: begin
            if (!rsp_stall) begin
               state_in = tmhq_pkg::S_IDLE;
            end
         end
         default: state_in = tmhq_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.status = tmhq_pkg::ST_OK;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         tmhq_pkg::S_IDLE: begin
            req_stall = 1'b0;
            cmd.load_req = req_valid;
         end
         tmhq_pkg::S_DECIDE: begin
            cmd.scan_start = 1'b1;
            if (sts.empty) begin
               if (sts.func == tmhq_pkg::FUNC_CHANGE) begin
                  cmd.set_status = 1'b1;
                  cmd.status = tmhq_pkg::ST_NOT_FOUND;
               end else if (sts.func != tmhq_pkg::FUNC_INSERT) begin
                  cmd.set_status = 1'b1;
                  cmd.status = tmhq_pkg::ST_EMPTY;
               end
            end
         end
         tmhq_pkg::S_SCAN_RD: begin
         end
         tmhq_pkg::S_SCAN_CHK: begin
            if (sts.scan_hit) begin
               if (sts.func == tmhq_pkg::FUNC_INSERT) begin
                  cmd.set_status = 1'b1;
                  cmd.status = tmhq_pkg::ST_DUPLICATE;
               end else begin
                  cmd.chg_start = 1'b1;
               end
            end else if (sts.scan_end) begin
               if (sts.func == tmhq_pkg::FUNC_CHANGE) begin
                  cmd.set_status = 1'b1;
                  cmd.status = tmhq_pkg::ST_NOT_FOUND;
               end
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         tmhq_pkg::S_INS: begin
            if (sts.full) begin
               cmd.set_status = 1'b1;
               cmd.status = tmhq_pkg::ST_FULL;
            end else begin
               cmd.ins_start = 1'b1;
            end
         end
         tmhq_pkg::S_ROOT_RD: cmd.root_read = 1'b1;
         tmhq_pkg::S_ROOT_CHK: cmd.latch_root = 1'b1;
         tmhq_pkg::S_LAST_RD: cmd.last_read = 1'b1;
         tmhq_pkg::S_LAST_CHK: cmd.load_last = 1'b1;
         tmhq_pkg::S_UP_RD: cmd.up_read = 1'b1;
         tmhq_pkg::S_UP_CHK: begin
            if (sts.up_top) begin
               cmd.up_place = 1'b1;
            end else if (sts.up_less) begin
               cmd.up_shift = 1'b1;
            end else begin
               cmd.up_place = 1'b1;
            end
         end
         tmhq_pkg::S_DN_RD: cmd.dn_read = 1'b1;
         tmhq_pkg::S_DN_CHK: cmd.dn_check = 1'b1;
         tmhq_pkg::S_DN_END: begin
            cmd.dn_place = sts.dn_stay;
            cmd.dn_shift = !sts.dn_stay;
         end
         tmhq_pkg::S_DONE: rsp_valid = 1'b1;
         default: begin
         end
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while result pending");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("stalled result dropped");
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == tmhq_pkg::S_DECIDE))
      else $error("accepted request not started");

endmodule

// ----- sv/tmhq_dp.sv -----
// Datapath: heap memory, count, scan pointer, sift position and result.
module tmhq_dp (
   input  logic                clock,
   input  logic                reset,
   input  tmhq_pkg::req_type   req_data,
   input  tmhq_pkg::cmd_type   cmd,
   output tmhq_pkg::sts_type   sts,
   output tmhq_pkg::rsp_type   rsp_data
);

   localparam int IB = tmhq_pkg::IDX_BITS;
   localparam int CB = tmhq_pkg::CNT_BITS;
   localparam int KB = tmhq_pkg::KEY_BITS;
   localparam int WB = tmhq_pkg::ID_BITS + KB;
   localparam int PB = IB + tmhq_pkg::DIV3_SHIFT;

   // One entry = {id, key}; single write port, one registered read port.
   logic [WB-1:0] mem [tmhq_pkg::CAPACITY];

   tmhq_pkg::func_type            func_ff;
   logic [tmhq_pkg::ID_BITS-1:0]  id_ff;
   logic [KB-1:0]                 key_ff;
   logic [CB-1:0]                 cnt_ff;
   logic [CB-1:0]                 ptr_ff;
   logic [IB-1:0]                 pos_ff;  // hole the mover sits in
   logic [IB-1:0]                 best_ff;
   logic [WB-1:0]                 cur_ff;  // mover entry
   logic [WB-1:0]                 bent_ff; // best candidate entry
   logic [1:0]                    ci_ff;   // child being read
   logic [WB-1:0]                 rd_ff;
   tmhq_pkg::status_type          stat_ff;
   logic [WB-1:0]                 root_ff;

   logic                          we;
   logic [IB-1:0]                 raddr;
   logic [WB-1:0]                 wdata;
   logic [IB-1:0]                 pos_m1;
   logic [PB-1:0]                 parent_w;
   logic [IB-1:0]                 parent;
   logic [7:0]                    child_w;
   logic [CB-1:0]                 last_idx;
   logic [IB-1:0]                 start_pos;
   logic                          child_ok;
   logic                          dn_greater;

   // Parent of the hole: (pos - 1) / 3 through a reciprocal multiply.
   assign pos_m1   = pos_ff - IB'(1);
   assign parent_w = PB'(pos_m1) * PB'(tmhq_pkg::DIV3_MUL);
   assign parent   = parent_w[PB-1:tmhq_pkg::DIV3_SHIFT];
   assign child_w  = 8'(pos_ff) * 8'd3 + 8'(ci_ff) + 8'd1;
   assign child_ok = (child_w < 8'(cnt_ff));
   assign last_idx = cnt_ff - CB'(1);
   assign start_pos = cmd.ins_start ? cnt_ff[IB-1:0] : ptr_ff[IB-1:0];
   assign dn_greater = child_ok && (rd_ff[KB-1:0] > bent_ff[KB-1:0]);

   always_comb begin
      priority if (cmd.up_read) begin
         raddr = parent;
      end else if (cmd.dn_read) begin
         raddr = child_w[IB-1:0];
      end else if (cmd.root_read) begin
         raddr = '0;
      end else if (cmd.last_read) begin
         raddr = last_idx[IB-1:0];
      end else begin
         raddr = ptr_ff[IB-1:0];
      end
   end

   // Every write goes to the hole.
   assign we = cmd.up_shift | cmd.up_place | cmd.dn_shift | cmd.dn_place;
   assign wdata = cmd.up_shift ? rd_ff : (cmd.dn_shift ? bent_ff : cur_ff);

   always_ff @(posedge clock) begin
      rd_ff <= mem[raddr];
      if (we) begin
         mem[pos_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.ins_start) begin
         cnt_ff <= cnt_ff + CB'(1);
      end else if (cmd.load_last) begin
         cnt_ff <= cnt_ff - CB'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         func_ff <= tmhq_pkg::func_type'(req_data.func);
         id_ff   <= req_data.entry_id;
         key_ff  <= req_data.entry_key[KB-1:0];
         stat_ff <= tmhq_pkg::ST_OK;
         root_ff <= '0;
      end else if (cmd.set_status) begin
         stat_ff <= cmd.status;
      end else if (cmd.latch_root) begin
         root_ff <= rd_ff;
      end
      if (cmd.scan_start) begin
         ptr_ff <= '0;
      end else if (cmd.scan_next) begin
         ptr_ff <= ptr_ff + CB'(1);
      end
      if (cmd.ins_start || cmd.chg_start) begin
         cur_ff  <= {id_ff, key_ff};
         bent_ff <= {id_ff, key_ff};
         pos_ff  <= start_pos;
         best_ff <= start_pos;
         ci_ff   <= '0;
      end else if (cmd.load_last) begin
         cur_ff  <= rd_ff;
         bent_ff <= rd_ff;
         pos_ff  <= '0;
         best_ff <= '0;
         ci_ff   <= '0;
      end else if (cmd.up_shift) begin
         pos_ff <= parent;
      end else if (cmd.dn_check) begin
         if (dn_greater) begin
            bent_ff <= rd_ff;
            best_ff <= child_w[IB-1:0];
         end
         ci_ff <= ci_ff + 2'd1;
      end else if (cmd.dn_shift) begin
         pos_ff  <= best_ff;
         bent_ff <= cur_ff;
         ci_ff   <= '0;
      end
   end

   always_comb begin
      sts.func     = func_ff;
      sts.empty    = (cnt_ff == '0);
      sts.full     = (cnt_ff == CB'(tmhq_pkg::CAPACITY));
      sts.scan_hit = (rd_ff[WB-1:KB] == id_ff);
      sts.scan_end = (ptr_ff + CB'(1) >= cnt_ff);
      sts.key_up   = (key_ff > rd_ff[KB-1:0]);
      sts.up_top   = (pos_ff == '0);
      sts.up_less  = (rd_ff[KB-1:0] < cur_ff[KB-1:0]);
      sts.dn_last  = (ci_ff == 2'd2) || !child_ok;
      sts.dn_stay  = (best_ff == pos_ff);
   end

   assign rsp_data.status  = stat_ff;
   assign rsp_data.out_id  = root_ff[WB-1:KB];
   assign rsp_data.out_key = root_ff[KB-1:0];
   assign rsp_data.count   = cnt_ff;

endmodule

// ----- sim/tb_ternary_max_heap_queue.sv -----
// Testbench: ternary max-heap queue checked against an in-bench heap predictor.
module tb_ternary_max_heap_queue;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1500000;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   tmhq_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   tmhq_pkg::rsp_type rsp_data;

   ternary_max_heap_queue u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   // Predictor state: a mirror of the heap held by the block.
   logic [tmhq_pkg::ID_BITS-1:0]  mirror_ids  [tmhq_pkg::CAPACITY];
   logic [tmhq_pkg::KEY_BITS-1:0] mirror_keys [tmhq_pkg::CAPACITY];
   int                            mirror_count;

   tmhq_pkg::rsp_type pending_rsps[$];
   int      errors;
   int      cycles = 0;
   int      rsp_stall_cycles;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Abort on a hung block.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic void swap_mirror(int a, int b);
      logic [tmhq_pkg::ID_BITS-1:0]  ti;
      logic [tmhq_pkg::KEY_BITS-1:0] tk;
      ti = mirror_ids[a];  tk = mirror_keys[a];
      mirror_ids[a] = mirror_ids[b];  mirror_keys[a] = mirror_keys[b];
      mirror_ids[b] = ti;  mirror_keys[b] = tk;
   endfunction

   function automatic void bubble_up(int pos);
      int parent;
      while (pos > 0 && pos < mirror_count) begin
         parent = (pos - 1) / 3;
         if (mirror_keys[parent] >= mirror_keys[pos]) break;
         swap_mirror(parent, pos);
         pos = parent;
      end
   endfunction

   function automatic void bubble_down(int pos);
      int best;
      int child;
      while (pos < mirror_count) begin
         best = pos;
         for (int c = 1; c <= 3; c++) begin
            child = 3 * pos + c;
            if (child < mirror_count && mirror_keys[child] > mirror_keys[best]) best = child;
         end
         if (best == pos) break;
         swap_mirror(pos, best);
         pos = best;
      end
   endfunction

   function automatic int slot_of(logic [tmhq_pkg::ID_BITS-1:0] id);
      for (int i = 0; i < mirror_count; i++)
         if (mirror_ids[i] == id) return i;
      return -1;
   endfunction

   // Apply one operation to the mirror and return the result the block owes.
   function automatic tmhq_pkg::rsp_type heap_apply(tmhq_pkg::req_type r);
      tmhq_pkg::rsp_type             res;
      int                            slot;
      logic [tmhq_pkg::KEY_BITS-1:0] old_key;
      res = '0;
      res.status = tmhq_pkg::ST_OK;
      case (tmhq_pkg::func_type'(r.func))
         tmhq_pkg::FUNC_INSERT: begin
            if (slot_of(r.entry_id) >= 0) res.status = tmhq_pkg::ST_DUPLICATE;
            else if (mirror_count >= tmhq_pkg::CAPACITY) res.status = tmhq_pkg::ST_FULL;
            else begin
               mirror_ids[mirror_count]  = r.entry_id;
               mirror_keys[mirror_count] = r.entry_key;
               mirror_count++;
               bubble_up(mirror_count - 1);
            end
         end
         tmhq_pkg::FUNC_EXTRACT, tmhq_pkg::FUNC_PEEK: begin
            if (mirror_count == 0) res.status = tmhq_pkg::ST_EMPTY;
            else begin
               res.out_id  = mirror_ids[0];
               res.out_key = mirror_keys[0];
               if (tmhq_pkg::func_type'(r.func) == tmhq_pkg::FUNC_EXTRACT) begin
                  mirror_count--;
                  mirror_ids[0]  = mirror_ids[mirror_count];
                  mirror_keys[0] = mirror_keys[mirror_count];
                  bubble_down(0);
               end
            end
         end
         default: begin
            slot = slot_of(r.entry_id);
            if (slot < 0) res.status = tmhq_pkg::ST_NOT_FOUND;
            else begin
               old_key = mirror_keys[slot];
               mirror_keys[slot] = r.entry_key;
               if (r.entry_key > old_key) bubble_up(slot);
               else bubble_down(slot);
            end
         end
      endcase
      res.count = mirror_count[tmhq_pkg::CNT_BITS-1:0];
      return res;
   endfunction

   // Result side: draw a stall length per item, then compare with the oldest expectation.
   always @(posedge clock) begin : rsp_side
      int                hold;
      tmhq_pkg::rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_stall_cycles <= 0;
      end else begin
         hold = rsp_stall_cycles;
         if (rsp_valid && !rsp_stall) begin
            if (pending_rsps.size() == 0) begin
               $display("%0t: unexpected item, expected none, actual %p", $time, rsp_data);
               errors++;
            end else begin
               want = pending_rsps.pop_front();
               if (rsp_data.status !== want.status)
                  $display("%0t: status expected %0d actual %0d", $time, want.status,
                           rsp_data.status);
               if (rsp_data.out_id !== want.out_id)
                  $display("%0t: out_id expected %0d actual %0d", $time, want.out_id,
                           rsp_data.out_id);
               if (rsp_data.out_key !== want.out_key)
                  $display("%0t: out_key expected %0d actual %0d", $time, want.out_key,
                           rsp_data.out_key);
               if (rsp_data.count !== want.count)
                  $display("%0t: count expected %0d actual %0d", $time, want.count,
                           rsp_data.count);
               if (rsp_data !== want) errors++;
            end
            // Pick the hold-off for the next item; sometimes no stall at all.
            hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            rsp_stall_cycles <= hold - 1;
         end else begin
            rsp_stall <= 1'b0;
            rsp_stall_cycles <= 0;
         end
      end
   end

   // Send one item after a random gap; the predictor runs at acceptance.
   // Valid stays high after acceptance until the next item or the gap drops it.
   task automatic send_item(tmhq_pkg::func_type f, logic [15:0] id, logic [7:0] key,
                            bit burst = 0);
      int                gap;
      tmhq_pkg::req_type r;
      gap = burst ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      r.func = f;  r.entry_id = id;  r.entry_key = key;
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      pending_rsps.push_back(heap_apply(r));
   endtask

   // Directed: extremes, empty cases, duplicates, ties, not found.
   task automatic test_directed();
      send_item(tmhq_pkg::FUNC_EXTRACT, 16'h0000, 8'h00);
      send_item(tmhq_pkg::FUNC_PEEK, 16'hFFFF, 8'hFF);
      send_item(tmhq_pkg::FUNC_CHANGE, 16'h1234, 8'h55);
      send_item(tmhq_pkg::FUNC_INSERT, 16'hFFFF, 8'hFF);
      send_item(tmhq_pkg::FUNC_INSERT, 16'h0000, 8'h00);
      send_item(tmhq_pkg::FUNC_INSERT, 16'hFFFF, 8'h10);
      send_item(tmhq_pkg::FUNC_INSERT, 16'h5555, 8'hFF);
      send_item(tmhq_pkg::FUNC_INSERT, 16'hAAAA, 8'hAA);
      send_item(tmhq_pkg::FUNC_PEEK, 16'h0000, 8'h00);
      send_item(tmhq_pkg::FUNC_CHANGE, 16'h0000, 8'hFF);
      send_item(tmhq_pkg::FUNC_CHANGE, 16'hFFFF, 8'h00);
      send_item(tmhq_pkg::FUNC_CHANGE, 16'h4321, 8'h01);
      send_item(tmhq_pkg::FUNC_CHANGE, 16'hAAAA, 8'hAA);
      repeat (5) send_item(tmhq_pkg::FUNC_EXTRACT, 16'h0000, 8'h00);
   endtask

   // Fill to capacity, overflow with fresh and duplicate ids, then drain.
   task automatic test_full();
      for (int i = 0; i < tmhq_pkg::CAPACITY; i++)
         send_item(tmhq_pkg::FUNC_INSERT, 16'(i * 977 + 3), 8'($urandom_range(0, 255)), 1);
      send_item(tmhq_pkg::FUNC_INSERT, 16'hBEEF, 8'h80);
      send_item(tmhq_pkg::FUNC_INSERT, 16'd3, 8'h80);
      send_item(tmhq_pkg::FUNC_CHANGE, 16'(63 * 977 + 3), 8'hFF);
      for (int i = 0; i < tmhq_pkg::CAPACITY + 1; i++)
         send_item(tmhq_pkg::FUNC_EXTRACT, 16'h0, 8'h0, 1);
   endtask

   // Random mix; ids from a small pool so duplicates and hits are common,
   // and now and then a full-range id so every bit toggles.
   task automatic test_random(int n);
      tmhq_pkg::func_type f;
      logic [15:0]        id;
      logic [7:0]         key;
      for (int i = 0; i < n; i++) begin
         f   = tmhq_pkg::func_type'($urandom_range(0, 3));
         if ($urandom_range(0, 9) < 4) f = tmhq_pkg::FUNC_INSERT;
         id  = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 80));
         key = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
         send_item(f, id, key, $urandom_range(0, 4) == 0);
      end
   endtask

   initial begin
      errors = 0;
      mirror_count = 0;
      req_valid = 1'b0;
      req_data  = '0;
      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full();
      test_random(1100);
      req_valid <= 1'b0;
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
